>>> rtl/core/bfwt_pkg.sv
// Package for the bucketed feature weight table: widths, command codes, shared types.
// No dependencies.
package bfwt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int FEATURE_DIMS  = 2;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int KEY_W         = 64;
    localparam int WORD_W        = 32;
    localparam int SIZE_W        = 31;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic REG_BUCKET_SIZE_0 = 1'b0;
    localparam logic REG_BUCKET_SIZE_1 = 1'b1;

    // Search result passed from the search engine to the top level.
    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             have_free;
        logic [IDX_W-1:0] free_idx;
    } search_res_t;

endpackage

>>> rtl/core/bfwt_divider.sv
// Restoring divider: signed dividend by unsigned divisor, truncating toward zero.
// Depends on bfwt_pkg. One quotient bit per cycle.
module bfwt_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bfwt_pkg::WORD_W-1:0]    dividend,
    input  logic [bfwt_pkg::SIZE_W-1:0]    divisor,
    output logic                           done,
    output logic [bfwt_pkg::WORD_W-1:0]    quotient
);
    import bfwt_pkg::*;

    localparam int STEP_W = $clog2(WORD_W + 1);

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [SIZE_W-1:0] dsr_reg, dsr_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W-1:0] q_mag;

    assign trial = {rem_reg, quo_reg[WORD_W-1]} - {2'b00, dsr_reg};
    assign q_mag = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            neg_next  = dividend[WORD_W-1];
            quo_next  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = STEP_W'(WORD_W);
            busy_next = 1'b1;
            if (divisor == '0)
            begin
                quo_next  = '0;
                neg_next  = 1'b0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (WORD_W'(0) - q_mag) : q_mag;

endmodule

>>> rtl/core/bfwt_store.sv
// Entry store: valid flags in flops, key and weight in synchronous memories with registered reads.
// Depends on bfwt_pkg.
module bfwt_store
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          clear_all,
    input  logic [bfwt_pkg::IDX_W-1:0]    rd_idx,
    output logic                          rd_valid,
    output logic [bfwt_pkg::KEY_W-1:0]    rd_key,
    output logic [bfwt_pkg::WORD_W-1:0]   rd_weight,
    input  logic                          wr_en,
    input  logic                          wr_key_en,
    input  logic [bfwt_pkg::IDX_W-1:0]    wr_idx,
    input  logic [bfwt_pkg::KEY_W-1:0]    wr_key,
    input  logic [bfwt_pkg::WORD_W-1:0]   wr_weight
);
    import bfwt_pkg::*;

    logic [KEY_W-1:0]         key_mem [TABLE_ENTRIES];
    logic [WORD_W-1:0]        wt_mem  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wt_mem[wr_idx] <= wr_weight;
            if (wr_key_en)
            begin
                key_mem[wr_idx] <= wr_key;
            end
        end
        rd_key    <= key_mem[rd_idx];
        rd_weight <= wt_mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_idx];
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en && wr_key_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    assign rd_valid = rd_valid_reg;

endmodule

>>> rtl/core/bucketed_feature_weight_table.sv
// Bucketed feature weight table top level: handshakes, config, command sequencer.
// Depends on bfwt_pkg, bfwt_divider, bfwt_store.
// Query and update run two divides, a key scan over all TABLE_ENTRIES and a weight reread;
//   clear and the unused command go straight to the output.
// Throughput: one item at a time; set by the bit-serial divider and the one-entry-a-cycle
//   key scan through the store's read port. Reset empties the table at once (valid flops).
module bucketed_feature_weight_table
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // [1:0] command, [33:2] feature_value_0,
                                    // [65:34] feature_value_1, [97:66] delta, [103:98] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // [31:0] weight
    output logic [1:0]   m_tuser,   // [0] found, [1] table_full
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_index,
    input  logic [30:0]  cfg_data
);
    import bfwt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV0, ST_DIV1, ST_SCAN, ST_READ, ST_DECIDE, ST_OUT
    } state_t;

    state_t             state_reg;
    logic [SIZE_W-1:0]  bsize0_reg, bsize1_reg;
    cmd_t               cmd_reg;
    logic [WORD_W-1:0]  v1_reg, delta_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [CNT_W-1:0]   scan_reg;
    logic               rd_pend_reg;
    logic [IDX_W-1:0]   rd_idx_pend_reg;
    search_res_t        srch_reg;
    logic [WORD_W-1:0]  out_w_reg;
    logic               out_found_reg, out_full_reg;
    logic               out_valid_reg;

    logic               div_start;
    logic [WORD_W-1:0]  div_dvd;
    logic [SIZE_W-1:0]  div_dsr;
    logic               div_done;
    logic [WORD_W-1:0]  div_q;
    logic               st_rd_valid;
    logic [KEY_W-1:0]   st_rd_key;
    logic [WORD_W-1:0]  st_rd_wt;
    logic               wr_en, wr_key_en, clear_all;
    logic [IDX_W-1:0]   wr_idx, rd_idx;
    logic [WORD_W-1:0]  wr_wt;
    logic [WORD_W:0]    sum;
    logic [WORD_W-1:0]  sat;
    logic               s_fire;
    logic               unused_pad;

    assign unused_pad = ^s_tdata[103:98];
    assign s_tready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_fire     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;

    assign div_start = s_fire && (s_tdata[1:0] == CMD_QUERY || s_tdata[1:0] == CMD_UPDATE)
                       || (state_reg == ST_DIV0 && div_done && FEATURE_DIMS >= 2);
    assign div_dvd   = (state_reg == ST_IDLE) ? s_tdata[33:2] : v1_reg;
    assign div_dsr   = (state_reg == ST_IDLE) ? bsize0_reg : bsize1_reg;

    bfwt_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    // Scan reads entry scan_reg; the READ cycle rereads the hit entry for its weight.
    assign rd_idx = (state_reg == ST_SCAN) ? scan_reg[IDX_W-1:0] : srch_reg.hit_idx;

    bfwt_store u_store
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear_all (clear_all),
        .rd_idx    (rd_idx),
        .rd_valid  (st_rd_valid),
        .rd_key    (st_rd_key),
        .rd_weight (st_rd_wt),
        .wr_en     (wr_en),
        .wr_key_en (wr_key_en),
        .wr_idx    (wr_idx),
        .wr_key    (key_reg),
        .wr_weight (wr_wt)
    );

    assign clear_all = s_fire && (s_tdata[1:0] == CMD_CLEAR);

    // Saturating add of the stored weight and delta.
    assign sum = {st_rd_wt[WORD_W-1], st_rd_wt} + {delta_reg[WORD_W-1], delta_reg};
    always_comb
    begin
        if (sum[WORD_W] != sum[WORD_W-1])
        begin
            sat = sum[WORD_W] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
        end
        else
        begin
            sat = sum[WORD_W-1:0];
        end
    end

    always_comb
    begin
        wr_en     = 1'b0;
        wr_key_en = 1'b0;
        wr_idx    = srch_reg.hit_idx;
        wr_wt     = sat;
        if (state_reg == ST_DECIDE && cmd_reg == CMD_UPDATE)
        begin
            if (srch_reg.hit)
            begin
                wr_en = 1'b1;
            end
            else if (srch_reg.have_free)
            begin
                wr_en     = 1'b1;
                wr_key_en = 1'b1;
                wr_idx    = srch_reg.free_idx;
                wr_wt     = delta_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            bsize0_reg      <= SIZE_W'(65536);
            bsize1_reg      <= SIZE_W'(65536);
            scan_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            srch_reg        <= '0;
            cmd_reg         <= CMD_QUERY;
            v1_reg          <= '0;
            delta_reg       <= '0;
            key_reg         <= '0;
            rd_idx_pend_reg <= '0;
            out_w_reg       <= '0;
            out_found_reg   <= 1'b0;
            out_full_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_BUCKET_SIZE_0)
                begin
                    bsize0_reg <= cfg_data;
                end
                else
                begin
                    bsize1_reg <= cfg_data;
                end
            end
            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        cmd_reg   <= cmd_t'(s_tdata[1:0]);
                        v1_reg    <= s_tdata[65:34];
                        delta_reg <= s_tdata[97:66];
                        if (s_tdata[1:0] == CMD_QUERY || s_tdata[1:0] == CMD_UPDATE)
                        begin
                            state_reg <= ST_DIV0;
                        end
                        else
                        begin
                            out_w_reg     <= '0;
                            out_found_reg <= 1'b0;
                            out_full_reg  <= 1'b0;
                            state_reg     <= ST_OUT;
                        end
                    end
                end
                ST_DIV0:
                begin
                    if (div_done)
                    begin
                        key_reg[WORD_W-1:0] <= div_q;
                        if (FEATURE_DIMS >= 2)
                        begin
                            state_reg <= ST_DIV1;
                        end
                        else
                        begin
                            key_reg[KEY_W-1:WORD_W] <= '0;
                            scan_reg  <= '0;
                            srch_reg  <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_DIV1:
                begin
                    if (div_done)
                    begin
                        key_reg[KEY_W-1:WORD_W] <= div_q;
                        scan_reg    <= '0;
                        srch_reg    <= '0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    // Issue read of scan_reg; compare data of previous read.
                    rd_pend_reg     <= (scan_reg < CNT_W'(TABLE_ENTRIES));
                    rd_idx_pend_reg <= scan_reg[IDX_W-1:0];
                    if (rd_pend_reg)
                    begin
                        if (st_rd_valid)
                        begin
                            if (!srch_reg.hit && st_rd_key == key_reg)
                            begin
                                srch_reg.hit     <= 1'b1;
                                srch_reg.hit_idx <= rd_idx_pend_reg;
                            end
                        end
                        else if (!srch_reg.have_free)
                        begin
                            srch_reg.have_free <= 1'b1;
                            srch_reg.free_idx  <= rd_idx_pend_reg;
                        end
                    end
                    if (scan_reg == CNT_W'(TABLE_ENTRIES))
                    begin
                        state_reg <= ST_READ;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                end
                ST_READ:
                begin
                    // Read of hit_idx issued here; its weight is on the store output next.
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    // Weight of the hit entry, read during READ, is present now.
                    out_found_reg <= srch_reg.hit;
                    out_full_reg  <= 1'b0;
                    if (srch_reg.hit)
                    begin
                        out_w_reg <= (cmd_reg == CMD_UPDATE) ? sat : st_rd_wt;
                    end
                    else if (cmd_reg == CMD_UPDATE && srch_reg.have_free)
                    begin
                        out_w_reg <= delta_reg;
                    end
                    else
                    begin
                        out_w_reg    <= '0;
                        out_full_reg <= (cmd_reg == CMD_UPDATE);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_w_reg;
    assign m_tuser  = {out_full_reg, out_found_reg};

endmodule
